// ===== hw/rtl/sdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrc_pkg : shared types and constants of the sector disk controller
// Offsets, status bits, access codes, payload structs, controller state and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sdrc_pkg;

  localparam int BUFFER_WORDS   = 128;
  localparam int MEDIUM_SECTORS = 256;
  localparam int BUF_AW         = $clog2(BUFFER_WORDS);
  localparam int CNT_W          = BUF_AW + 1;
  localparam int SEC_AW         = $clog2(MEDIUM_SECTORS);
  localparam int MED_AW         = SEC_AW + BUF_AW;
  localparam int MED_DEPTH      = MEDIUM_SECTORS * BUFFER_WORDS;

  // bus offsets
  localparam logic [15:0] OFS_COUNT  = 16'd0;
  localparam logic [15:0] OFS_STATUS = 16'd4;
  localparam logic [15:0] OFS_SECTOR = 16'd8;
  localparam logic [15:0] OFS_SPIN   = 16'd12;
  localparam logic [16:0] BUF_BASE   = 17'd32768;
  localparam logic [16:0] BUF_LIMIT  = BUF_BASE + 17'(4 * BUFFER_WORDS);

  // status commands
  localparam logic [31:0] CMD_IDLE  = 32'd0;
  localparam logic [31:0] CMD_READ  = 32'd1;
  localparam logic [31:0] CMD_WRITE = 32'd3;

  // status register bits
  localparam int ST_BUSY_BIT  = 0;
  localparam int ST_WR_BIT    = 1;
  localparam int ST_DONE_BIT  = 2;
  localparam int ST_INVAL_BIT = 3;

  // access status codes
  localparam logic [1:0] ACC_OK       = 2'd0;
  localparam logic [1:0] ACC_UNMAPPED = 2'd1;
  localparam logic [1:0] ACC_ILLEGAL  = 2'd2;

  // configuration register indexes
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_SPIN  = 1'b1;

  localparam logic [8:0]  TOTAL_RST = 9'd256;
  localparam logic [15:0] SPIN_RST  = 16'd3600;

  typedef struct packed {
    logic        mode;
    logic [15:0] bus_offset;
    logic [31:0] write_data;
  } sdrc_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  access_status;
    logic        irq;
  } sdrc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_COPY
  } sdrc_state_t;

  typedef struct packed {
    logic accept;
    logic finish_access;
    logic copy_init;
    logic copy_step;
    logic copy_finish;
  } sdrc_cmd_t;

  typedef struct packed {
    logic start_copy;
    logic copy_last;
  } sdrc_stat_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [31:0] data;
  } sdrc_cfg_wr_t;

endpackage

// ===== hw/rtl/sdrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdrc_ctrl : sequencer of the sector disk controller
// Steps each access through decode and, for a transfer, the sector copy.
// ----------------------------------------------------------------------------
module sdrc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sdrc_pkg::sdrc_stat_t stat,
  output sdrc_pkg::sdrc_cmd_t  cmd,
  output logic               busy
);
  import sdrc_pkg::*;

  sdrc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_nxt = stat.start_copy ? ST_COPY : ST_IDLE;
      end
      ST_COPY: begin
        if (stat.copy_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_ACCESS: begin
        cmd.finish_access = !stat.start_copy;
        cmd.copy_init     = stat.start_copy;
      end
      ST_COPY: begin
        cmd.copy_step   = 1'b1;
        cmd.copy_finish = stat.copy_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/sdrc_datapath.sv =====
// ----------------------------------------------------------------------------
// sdrc_datapath : registers, transfer buffer and medium of the controller
// Decodes the latched access, holds the copy counter and both memories.
// ----------------------------------------------------------------------------
module sdrc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdrc_pkg::sdrc_in_t   in_data,
  input  sdrc_pkg::sdrc_cmd_t  cmd,
  input  sdrc_pkg::sdrc_cfg_wr_t cfg_wr,
  input  logic                 cfg_rd_index,
  output sdrc_pkg::sdrc_stat_t stat,
  output logic [31:0]          cfg_rdata,
  output logic                 out_valid,
  output sdrc_pkg::sdrc_out_t  out_data
);
  import sdrc_pkg::*;

  sdrc_in_t    req_r;
  logic [8:0]  total_r;
  logic [15:0] spin_r;
  logic [3:0]  status_r, status_nxt;
  logic [31:0] sector_r, sector_nxt;
  logic        out_valid_r;
  sdrc_out_t   out_data_r;

  logic [CNT_W-1:0]  cnt_r;
  logic              pend_r;
  logic [BUF_AW-1:0] idx_d_r;

  logic [31:0] buf_mem [BUFFER_WORDS];
  logic [31:0] med_mem [MED_DEPTH];
  logic [31:0] buf_rdata_r, med_rdata_r;

  logic              in_buf, buf_bus_we, dir_wr, sec_bad;
  logic              start_copy;
  logic [BUF_AW-1:0] req_word, buf_raddr, buf_waddr;
  logic              buf_we, med_we;
  logic [31:0]       buf_wdata, rd;
  logic [1:0]        acc;
  logic [MED_AW-1:0] med_raddr, med_waddr;
  logic [3:0]        done_status;

  assign in_buf   = ({1'b0, req_r.bus_offset} >= BUF_BASE) &&
                    ({1'b0, req_r.bus_offset} <  BUF_LIMIT);
  assign req_word = req_r.bus_offset[BUF_AW+1:2];
  assign dir_wr   = req_r.write_data[ST_WR_BIT];
  assign sec_bad  = (sector_r >= {23'd0, total_r}) ||
                    (sector_r >= 32'(MEDIUM_SECTORS));

  // access decode, used in the access cycle
  always_comb begin
    rd         = '0;
    acc        = ACC_OK;
    status_nxt = status_r;
    sector_nxt = sector_r;
    start_copy = 1'b0;
    buf_bus_we = 1'b0;
    if (in_buf) begin
      if (req_r.mode) buf_bus_we = 1'b1;
      else            rd = buf_rdata_r;
    end else if (!req_r.mode) begin
      unique case (req_r.bus_offset)
        OFS_COUNT:  rd = {23'd0, total_r};
        OFS_STATUS: rd = {28'd0, status_r};
        OFS_SECTOR: rd = sector_r;
        OFS_SPIN:   rd = {16'd0, spin_r};
        default:    acc = ACC_UNMAPPED;
      endcase
    end else begin
      unique case (req_r.bus_offset)
        OFS_STATUS: begin
          if (req_r.write_data == CMD_IDLE) begin
            status_nxt = '0;
          end else if (req_r.write_data == CMD_READ ||
                       req_r.write_data == CMD_WRITE) begin
            if (sec_bad) begin
              status_nxt = '0;
              status_nxt[ST_INVAL_BIT] = 1'b1;
              status_nxt[ST_DONE_BIT]  = 1'b1;
              status_nxt[ST_WR_BIT]    = dir_wr;
            end else begin
              start_copy = 1'b1;
            end
          end else begin
            acc = ACC_ILLEGAL;
          end
        end
        OFS_SECTOR: sector_nxt = req_r.write_data;
        default:    acc = ACC_UNMAPPED;
      endcase
    end
  end

  always_comb begin
    done_status = '0;
    done_status[ST_DONE_BIT] = 1'b1;
    done_status[ST_WR_BIT]   = dir_wr;
  end

  assign stat.start_copy = start_copy;
  assign stat.copy_last  = (cnt_r == CNT_W'(BUFFER_WORDS));

  // memory ports
  assign buf_raddr = cmd.copy_step ? cnt_r[BUF_AW-1:0]
                                   : in_data.bus_offset[BUF_AW+1:2];
  assign buf_we    = (buf_bus_we && cmd.finish_access) || (pend_r && !dir_wr);
  assign buf_waddr = pend_r ? idx_d_r : req_word;
  assign buf_wdata = pend_r ? med_rdata_r : req_r.write_data;
  assign med_raddr = {sector_r[SEC_AW-1:0], cnt_r[BUF_AW-1:0]};
  assign med_waddr = {sector_r[SEC_AW-1:0], idx_d_r};
  assign med_we    = pend_r && dir_wr;

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rdata_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (med_we) med_mem[med_waddr] <= buf_rdata_r;
    med_rdata_r <= med_mem[med_raddr];
  end

  // copy pipeline: read at cnt, write in the next cycle at idx_d
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.copy_init) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.copy_step) begin
      pend_r <= !stat.copy_last;
      if (!stat.copy_last) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= cnt_r[BUF_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= TOTAL_RST;
      spin_r      <= SPIN_RST;
      status_r    <= '0;
      sector_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish_access || cmd.copy_finish;
      if (cfg_wr.we) begin
        if (cfg_wr.index == REG_TOTAL) total_r <= cfg_wr.data[8:0];
        else                           spin_r  <= cfg_wr.data[15:0];
      end
      if (cmd.finish_access) begin
        status_r <= status_nxt;
        sector_r <= sector_nxt;
      end else if (cmd.copy_finish) begin
        status_r <= done_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_access) begin
      out_data_r.read_data     <= rd;
      out_data_r.access_status <= acc;
      out_data_r.irq           <= status_nxt[ST_DONE_BIT];
    end else if (cmd.copy_finish) begin
      out_data_r.read_data     <= '0;
      out_data_r.access_status <= ACC_OK;
      out_data_r.irq           <= 1'b1;
    end
  end

  assign cfg_rdata = (cfg_rd_index == REG_SPIN) ? {16'd0, spin_r} : {23'd0, total_r};
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/sector_disk_register_controller_unit.sv =====
// ----------------------------------------------------------------------------
// sector_disk_register_controller_unit : bus-register disk controller
// Register and buffer access over a start/busy command port, sector copies
// between a 128-word transfer buffer and an on-chip medium, APB config.
// ----------------------------------------------------------------------------
// Flow: a register or buffer access is decoded and its result registered; a
//   transfer command on a valid sector runs the sector copy first.
// One access at a time: busy holds off the next until the last is through;
//   the copy moves one word a cycle through the registered memory read ports.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low): idle, status and sector cleared, config
//   back to 256 sectors / 3600 rpm; buffer and medium stay uninitialised.
module sector_disk_register_controller_unit (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  sdrc_pkg::sdrc_in_t  in_data,
  // result channel
  output logic                out_valid,
  output sdrc_pkg::sdrc_out_t out_data,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sdrc_pkg::*;

  sdrc_cmd_t    cmd;
  sdrc_stat_t   stat;
  sdrc_cfg_wr_t cfg_wr;

  // APB: pready is always high; register picked by the word address bit.
  // Low address bits are ignored, so an unaligned write hits the word.
  assign pready       = 1'b1;
  assign cfg_wr.we    = psel && penable && pwrite;
  assign cfg_wr.index = paddr[2];
  assign cfg_wr.data  = pwdata;

  // Sequencer: idle -> access decode -> (optional) sector copy -> idle.
  sdrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Registers, memories and the copy counter.
  sdrc_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cmd          (cmd),
    .cfg_wr       (cfg_wr),
    .cfg_rd_index (paddr[2]),
    .stat         (stat),
    .cfg_rdata    (prdata),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

// ===== hw/rtl/sdrc_checker.sv =====
// ----------------------------------------------------------------------------
// sdrc_checker : port-level checks of the sector disk controller
// Command/result sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
module sdrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input sdrc_pkg::sdrc_in_t  in_data,
  input logic                out_valid,
  input sdrc_pkg::sdrc_out_t out_data
);
  import sdrc_pkg::*;

  // an accepted transfer keeps the block busy and no result in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accept not followed by busy");

  // a result is shown as the block goes back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // results are never strobed in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // failed accesses return no data, and no code beyond illegal
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.access_status != ACC_OK) |->
      (out_data.read_data == 32'd0 && out_data.access_status != 2'd3))
    else $error("bad result on failed access");

  // in_data is only sampled, kept visible for checks on the command side
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown(in_data.mode))
    else $error("unknown mode at accept");

endmodule

bind sector_disk_register_controller_unit sdrc_checker u_sdrc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for sector_disk_register_controller_unit
// Bus accesses go in over the start/busy port. Each is predicted against a
// local model of registers, buffer and medium, and checked against the one
// result strobed back. A buffer preload and a directed register map pass
// come first. Random phases follow under several sector-count and rpm
// settings, written over APB and read back, with differing sender idling.
// ----------------------------------------------------------------------------
module tb;
  import sdrc_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_ITEMS  = 330;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sdrc_in_t    in_data;
  logic        out_valid;
  sdrc_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sector_disk_register_controller_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the controller state
  logic [8:0]  disk_total  = TOTAL_RST;
  logic [15:0] disk_spin   = SPIN_RST;
  logic [3:0]  disk_status = '0;
  logic [31:0] disk_sector = '0;
  logic [31:0] buf_words    [BUFFER_WORDS];
  logic [31:0] medium_words [MED_DEPTH];
  // sectors the bench has written at least once; only these may be read back
  bit          sector_filled [MEDIUM_SECTORS];

  sdrc_out_t   pending_results[$];
  sdrc_out_t   oldest;
  int          fault_count = 0;
  int          cycle_count = 0;
  int          idle_pct    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("sector_disk_register_controller_unit verification failed");
      $finish;
    end
  end

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  function automatic bit sector_out_of_range();
    return disk_sector >= 32'(disk_total) || disk_sector >= 32'(MEDIUM_SECTORS);
  endfunction

  // Predicts one access and advances the local state.
  function automatic sdrc_out_t disk_access(input sdrc_in_t a);
    sdrc_out_t         r;
    logic [BUF_AW-1:0] w;
    int                base;
    r = '0;
    r.access_status = ACC_OK;
    w = a.bus_offset[BUF_AW+1:2];   // low two bits dropped: word holding the byte
    if ({1'b0, a.bus_offset} >= BUF_BASE && {1'b0, a.bus_offset} < BUF_LIMIT) begin
      if (a.mode) buf_words[w] = a.write_data;
      else        r.read_data = buf_words[w];
    end else if (!a.mode) begin
      case (a.bus_offset)
        OFS_COUNT:  r.read_data = 32'(disk_total);
        OFS_STATUS: r.read_data = 32'(disk_status);
        OFS_SECTOR: r.read_data = disk_sector;
        OFS_SPIN:   r.read_data = 32'(disk_spin);
        default:    r.access_status = ACC_UNMAPPED;
      endcase
    end else begin
      case (a.bus_offset)
        OFS_STATUS: begin
          if (a.write_data == CMD_IDLE || a.write_data == CMD_READ ||
              a.write_data == CMD_WRITE) begin
            disk_status = a.write_data[3:0];
            if (a.write_data != CMD_IDLE) begin
              // command completes within the access
              disk_status[ST_BUSY_BIT] = 1'b0;
              disk_status[ST_DONE_BIT] = 1'b1;
              if (sector_out_of_range()) begin
                disk_status[ST_INVAL_BIT] = 1'b1;
              end else begin
                base = int'(disk_sector[SEC_AW-1:0]) * BUFFER_WORDS;
                if (a.write_data[ST_WR_BIT]) begin
                  for (int i = 0; i < BUFFER_WORDS; i++) medium_words[base + i] = buf_words[i];
                  sector_filled[disk_sector[SEC_AW-1:0]] = 1'b1;
                end else begin
                  for (int i = 0; i < BUFFER_WORDS; i++) buf_words[i] = medium_words[base + i];
                end
              end
            end
          end else begin
            r.access_status = ACC_ILLEGAL;
          end
        end
        OFS_SECTOR: disk_sector = a.write_data;
        default:    r.access_status = ACC_UNMAPPED;
      endcase
    end
    r.irq = disk_status[ST_DONE_BIT];
    return r;
  endfunction

  // A sector read of a never-written sector would pull undefined medium
  // words into the buffer, so it is turned into a sector write instead.
  function automatic sdrc_in_t guard_access(input sdrc_in_t a);
    if (a.mode && a.bus_offset == OFS_STATUS && a.write_data == CMD_READ &&
        !sector_out_of_range() && !sector_filled[disk_sector[SEC_AW-1:0]])
      a.write_data = CMD_WRITE;
    return a;
  endfunction

  function automatic sdrc_in_t access(input logic m, input logic [15:0] ofs,
                                      input logic [31:0] data);
    sdrc_in_t a;
    a.mode       = m;
    a.bus_offset = ofs;
    a.write_data = data;
    return a;
  endfunction

  // Mostly well-formed traffic with random content; the rest is noise.
  function automatic sdrc_in_t random_access();
    int          pick;
    int          sub;
    logic [31:0] d;
    pick = $urandom_range(99);
    sub  = $urandom_range(9);
    if (pick < 25) return access(1'b1, 16'(32768 + $urandom_range(511)), $urandom);
    if (pick < 45) return access(1'b0, 16'(32768 + $urandom_range(511)), $urandom);
    if (pick < 55) return access(1'b0, {12'd0, 2'($urandom_range(3)), 2'b00}, $urandom);
    if (pick < 65) begin
      if (sub < 5)      d = $urandom_range(15);
      else if (sub < 8) d = $urandom_range(int'(disk_total) + 8);
      else              d = $urandom;
      return access(1'b1, OFS_SECTOR, d);
    end
    if (pick < 80) begin
      case ($urandom_range(4))
        0:       d = CMD_IDLE;
        1, 2:    d = CMD_READ;
        default: d = CMD_WRITE;
      endcase
      return access(1'b1, OFS_STATUS, d);
    end
    if (pick < 85) begin
      d = $urandom;
      if (d == CMD_IDLE || d == CMD_READ || d == CMD_WRITE) d = 32'd2;
      return access(1'b1, OFS_STATUS, d);
    end
    if (pick < 90) begin
      case (sub % 4)
        0:       return access(1'b1, OFS_COUNT, $urandom);
        1:       return access(1'b1, OFS_SPIN, $urandom);
        2:       return access(1'($urandom), 16'($urandom_range(16, 32767)), $urandom);
        default: return access(1'($urandom), 16'($urandom_range(33280, 65535)), $urandom);
      endcase
    end
    return access(1'($urandom), 16'($urandom), $urandom);
  endfunction

  // One access: held on the port until the transfer, then an optional gap.
  task automatic send_access(input sdrc_in_t a);
    sdrc_in_t item;
    item = guard_access(a);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(disk_access(item));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Sender holds off until every expected result is in and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_TOTAL) disk_total = value[8:0];
    else                  disk_spin  = value[15:0];
    readback = (idx == REG_TOTAL) ? 32'(disk_total) : 32'(disk_spin);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== readback)
      note_fault($sformatf("cfg reg %0d read back %0h, expected %0h", idx, prdata, readback));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: receiver never stalls, every strobe is a transfer.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result %0h/%0d/%0d", out_data.read_data,
                             out_data.access_status, out_data.irq));
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.read_data !== oldest.read_data ||
            out_data.access_status !== oldest.access_status ||
            out_data.irq !== oldest.irq)
          note_fault($sformatf("result data %0h acc %0d irq %0d, expected %0h/%0d/%0d",
                               out_data.read_data, out_data.access_status, out_data.irq,
                               oldest.read_data, oldest.access_status, oldest.irq));
      end
    end
  end

  // Every buffer word written once so that no read touches undefined data.
  task automatic test_buffer_preload();
    for (int i = 0; i < BUFFER_WORDS; i++)
      send_access(access(1'b1, 16'(32768 + 4 * i), $urandom));
    wait_idle();
  endtask

  // Register map, edges of the buffer window and every status command.
  task automatic test_register_map();
    send_access(access(1'b0, OFS_COUNT, '0));
    send_access(access(1'b0, OFS_SPIN, '0));
    send_access(access(1'b0, OFS_STATUS, '0));
    send_access(access(1'b0, OFS_SECTOR, '0));
    send_access(access(1'b1, OFS_COUNT, 32'hFFFF_FFFF));   // read-only
    send_access(access(1'b1, OFS_SPIN, 32'h1234_5678));    // read-only
    send_access(access(1'b0, 16'hFFFF, '0));
    send_access(access(1'b0, 16'h7FFF, '0));               // just below buffer
    send_access(access(1'b0, 16'h8200, '0));               // just past buffer
    send_access(access(1'b1, 16'h8200, 32'hDEAD_BEEF));
    send_access(access(1'b0, 16'h8003, '0));               // unaligned
    send_access(access(1'b1, 16'h81FE, 32'hFFFF_FFFF));
    send_access(access(1'b0, 16'h81FF, '0));
    // last valid sector: write out, then read back in
    send_access(access(1'b1, OFS_SECTOR, 32'd255));
    send_access(access(1'b1, OFS_STATUS, CMD_WRITE));
    send_access(access(1'b0, OFS_STATUS, '0));
    send_access(access(1'b1, OFS_STATUS, CMD_READ));
    send_access(access(1'b1, OFS_STATUS, CMD_IDLE));
    // first sector beyond the medium, and the largest sector number
    send_access(access(1'b1, OFS_SECTOR, 32'd256));
    send_access(access(1'b1, OFS_STATUS, CMD_READ));
    send_access(access(1'b1, OFS_STATUS, CMD_WRITE));
    send_access(access(1'b1, OFS_SECTOR, 32'hFFFF_FFFF));
    send_access(access(1'b1, OFS_STATUS, CMD_WRITE));
    // illegal commands leave the status alone
    send_access(access(1'b1, OFS_STATUS, 32'd2));
    send_access(access(1'b1, OFS_STATUS, 32'hFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_random_phase(input logic [8:0] sectors, input logic [15:0] rpm,
                                   input int idle);
    wait_idle();
    cfg_write(REG_TOTAL, 32'(sectors));
    cfg_write(REG_SPIN, 32'(rpm));
    idle_pct = idle;
    repeat (PHASE_ITEMS) send_access(random_access());
    wait_idle();
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_buffer_preload();
    test_register_map();
    test_random_phase(9'd128, 16'd60,    77);
    test_random_phase(9'd511, 16'd65520, 33);
    test_random_phase(9'd0,   16'd65535, 0);
    test_random_phase(9'd300, 16'd0,     77);
    test_random_phase(9'd200, 16'd3600,  33);
    test_random_phase(9'd256, 16'd120,   0);

    repeat (10) @(posedge clk);   // catch stray results
    if (fault_count == 0) begin
      $display("sector_disk_register_controller_unit verification clean");
    end else begin
      $display("sector_disk_register_controller_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sdrc_pkg.sv
hw/rtl/sdrc_ctrl.sv
hw/rtl/sdrc_datapath.sv
hw/rtl/sector_disk_register_controller_unit.sv
hw/rtl/sdrc_checker.sv
tb/tb.sv
